>>> hdl/fmpf_pkg.sv
package fmpf_pkg;

    // Default configuration of the rule table.
    localparam int MAX_RULES_DEF = 16;
    localparam int WILDCARD_DEF  = 0;

    // Fixed field widths of the item interface.
    localparam int ADDR_W      = 32;
    localparam int PROTO_W     = 8;
    localparam int PORT_W      = 16;
    localparam int ACTION_W    = 8;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_NOW_W = 5;

    // Item function codes.
    localparam logic [FUNC_W-1:0] FUNC_EVAL  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    // Rule actions.
    localparam logic [ACTION_W-1:0] ACT_DROP   = 8'd0;
    localparam logic [ACTION_W-1:0] ACT_ACCEPT = 8'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

    // One stored rule; addresses are kept already masked.
    typedef struct packed {
        logic [ADDR_W-1:0]  saddr;
        logic [ADDR_W-1:0]  smask;
        logic [ADDR_W-1:0]  daddr;
        logic [ADDR_W-1:0]  dmask;
        logic [PROTO_W-1:0] proto;
        logic [PORT_W-1:0]  sport;
        logic [PORT_W-1:0]  dport;
        logic               action;
    } rule_t;

    // Packet header under evaluation.
    typedef struct packed {
        logic [ADDR_W-1:0]  saddr;
        logic [ADDR_W-1:0]  daddr;
        logic [PROTO_W-1:0] proto;
        logic [PORT_W-1:0]  sport;
        logic [PORT_W-1:0]  dport;
    } pkt_t;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic valid;
        logic hit;
        logic verdict;
    } tok_t;

    // True when the mask is a run of ones from the top bit followed by zeros.
    function automatic logic prefix_ok(input logic [ADDR_W-1:0] m);
        logic [ADDR_W-1:0] inv;
        inv = ~m;
        return (inv & (inv + ADDR_W'(1))) == '0;
    endfunction

endpackage

>>> hdl/fmpf_cell.sv
module fmpf_cell
    import fmpf_pkg::*;
#(
    parameter int IDX            = 0,
    parameter int CNT_W          = $clog2(MAX_RULES_DEF + 1),
    parameter int WILDCARD_VALUE = WILDCARD_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  rule_t            wr_rule,
    input  logic [CNT_W-1:0] count,
    input  pkt_t             pkt,
    input  tok_t             tok_in,
    output tok_t             tok_out
);

    localparam logic [PROTO_W-1:0] WC_PROTO = PROTO_W'(WILDCARD_VALUE);
    localparam logic [PORT_W-1:0]  WC_PORT  = PORT_W'(WILDCARD_VALUE);
    localparam logic [CNT_W-1:0]   MY_IDX   = CNT_W'(IDX);

    rule_t rule_reg;
    tok_t  tok_reg;
    tok_t  tok_next;
    logic  live;
    logic  match;

    // New rules are appended at the current count, so this cell takes the
    // write when the count points at it.
    always_ff @(posedge aclk) begin
        if (wr_en && (count == MY_IDX)) begin
            rule_reg <= wr_rule;
        end
    end

    assign live  = MY_IDX < count;
    assign match = ((rule_reg.proto == WC_PROTO) || (rule_reg.proto == pkt.proto))
                && ((rule_reg.sport == WC_PORT)  || (rule_reg.sport == pkt.sport))
                && ((rule_reg.dport == WC_PORT)  || (rule_reg.dport == pkt.dport))
                && ((pkt.saddr & rule_reg.smask) == rule_reg.saddr)
                && ((pkt.daddr & rule_reg.dmask) == rule_reg.daddr);

    // An earlier hit passes through untouched, which gives first-match order.
    always_comb begin
        tok_next = tok_in;
        if (!tok_in.hit && live && match) begin
            tok_next.hit     = 1'b1;
            tok_next.verdict = rule_reg.action;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> hdl/first_match_packet_filter_core.sv
// Channel   Direction  Handshake             Payload
// s_        in         s_valid / s_ready     func, addresses, ports, proto, masks, action
// m_        out        m_valid / m_ready     verdict, status, count_now
// cfg_      in         cfg_wr_en             cfg_wr_data (default verdict)
//
// An add, clear or unused item passes from IDLE through HOLD back to IDLE before
// the next acceptance. An evaluate item also passes through SCAN, where a search
// token walks the chain of rule cells one cell per cycle until it leaves the last cell.
// Reset is synchronous and active low; it empties the table and the output
// register. The stored rules themselves are not cleared. A stalled result
// waits in the pending register until the output register is free.
module first_match_packet_filter_core
    import fmpf_pkg::*;
#(
    parameter int MAX_RULES      = MAX_RULES_DEF,
    parameter int WILDCARD_VALUE = WILDCARD_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic                   cfg_wr_data,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [FUNC_W-1:0]      s_func,
    input  logic [ADDR_W-1:0]      s_src_addr,
    input  logic [ADDR_W-1:0]      s_dst_addr,
    input  logic [PROTO_W-1:0]     s_proto,
    input  logic [PORT_W-1:0]      s_src_port,
    input  logic [PORT_W-1:0]      s_dst_port,
    input  logic [ADDR_W-1:0]      s_src_mask,
    input  logic [ADDR_W-1:0]      s_dst_mask,
    input  logic [ACTION_W-1:0]    s_rule_action,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_verdict,
    output logic [STATUS_W-1:0]    m_status,
    output logic [COUNT_NOW_W-1:0] m_count_now
);

    // The count must hold MAX_RULES itself.
    localparam int CNT_W  = $clog2(MAX_RULES + 1);
    localparam int WIDE_W = CNT_W + COUNT_NOW_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_RULES);

    state_t state_reg;
    state_t state_next;

    logic              dflt_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    pkt_t              pkt_reg;
    logic              start_reg;
    logic              start_next;
    logic              pend_verdict_reg;
    logic              pend_verdict_next;
    logic [STATUS_W-1:0] pend_status_reg;
    logic [STATUS_W-1:0] pend_status_next;

    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic                   m_verdict_reg;
    logic [STATUS_W-1:0]    m_status_reg;
    logic [COUNT_NOW_W-1:0] m_count_reg;
    logic [WIDE_W-1:0]      count_wide;

    logic  s_fire;
    logic  out_free;
    logic  load_out;
    logic  rule_ok;
    logic  table_full;
    logic  wr_en;
    rule_t wr_rule;
    tok_t  tok [0:MAX_RULES];

    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Rule check for an add item: a defined action and two prefix masks.
    assign rule_ok    = (s_rule_action <= ACT_ACCEPT) && prefix_ok(s_src_mask)
                      && prefix_ok(s_dst_mask);
    assign table_full = count_reg == FULL_CNT;
    assign wr_en      = s_fire && (s_func == FUNC_ADD) && rule_ok && !table_full;

    always_comb begin
        wr_rule.saddr  = s_src_addr & s_src_mask;
        wr_rule.smask  = s_src_mask;
        wr_rule.daddr  = s_dst_addr & s_dst_mask;
        wr_rule.dmask  = s_dst_mask;
        wr_rule.proto  = s_proto;
        wr_rule.sport  = s_src_port;
        wr_rule.dport  = s_dst_port;
        wr_rule.action = s_rule_action[0];
    end

    // Next state. Only one item is in the block at a time.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = (s_func == FUNC_EVAL) ? ST_SCAN : ST_HOLD;
                end
            end
            ST_SCAN: begin
                if (tok[MAX_RULES].valid) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State machine outputs.
    always_comb begin
        s_ready  = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready  = 1'b1;
            ST_SCAN: s_ready  = 1'b0;
            ST_HOLD: load_out = out_free;
            default: s_ready  = 1'b0;
        endcase
    end

    // Table count and the pending result of the item in flight.
    always_comb begin
        count_next        = count_reg;
        start_next        = s_fire && (s_func == FUNC_EVAL);
        pend_verdict_next = pend_verdict_reg;
        pend_status_next  = pend_status_reg;
        if (s_fire) begin
            pend_verdict_next = 1'b0;
            pend_status_next  = STATUS_OK;
            if (s_func == FUNC_ADD) begin
                priority if (!rule_ok) begin
                    pend_status_next = STATUS_INVALID;
                end else if (table_full) begin
                    pend_status_next = STATUS_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end else if (s_func == FUNC_CLEAR) begin
                count_next = '0;
            end
        end
        // The token leaving the last cell carries the first hit, if any.
        if (tok[MAX_RULES].valid) begin
            pend_verdict_next = tok[MAX_RULES].hit ? tok[MAX_RULES].verdict : dflt_reg;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign count_wide = WIDE_W'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            dflt_reg    <= 1'b0;
            count_reg   <= '0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                dflt_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        pend_verdict_reg <= pend_verdict_next;
        pend_status_reg  <= pend_status_next;
        if (s_fire) begin
            pkt_reg.saddr <= s_src_addr;
            pkt_reg.daddr <= s_dst_addr;
            pkt_reg.proto <= s_proto;
            pkt_reg.sport <= s_src_port;
            pkt_reg.dport <= s_dst_port;
        end
        if (load_out) begin
            m_verdict_reg <= pend_verdict_reg;
            m_status_reg  <= pend_status_reg;
            m_count_reg   <= count_wide[COUNT_NOW_W-1:0];
        end
    end

    // The search token enters the first cell the cycle after the packet
    // header has been captured.
    always_comb begin
        tok[0].valid   = start_reg;
        tok[0].hit     = 1'b0;
        tok[0].verdict = 1'b0;
    end

    for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
        fmpf_cell #(
            .IDX            (i),
            .CNT_W          (CNT_W),
            .WILDCARD_VALUE (WILDCARD_VALUE)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .wr_en   (wr_en),
            .wr_rule (wr_rule),
            .count   (count_reg),
            .pkt     (pkt_reg),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    assign m_valid     = m_valid_reg;
    assign m_verdict   = m_verdict_reg;
    assign m_status    = m_status_reg;
    assign m_count_now = m_count_reg;

endmodule
